// ===== rtl/ttpw_pkg.sv =====
// Shared types, constants and the RGB5A3 packing function for the tiled
// texture pixel writer. No dependencies; every other file imports this one.

package ttpw_pkg;

  // Field widths
  localparam int unsigned CoordW   = 10;
  localparam int unsigned DimW     = 11;
  localparam int unsigned OffsW    = 11;
  localparam int unsigned BaseW    = 24;
  localparam int unsigned AddrW    = 25;
  localparam int unsigned WordW    = 16;
  localparam int unsigned PixelW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned TileW    = 16;
  localparam int unsigned SInW     = 56;
  localparam int unsigned MOutW    = 88;

  // Largest level edge in texels; bigger register values clamp to it
  localparam int unsigned MaxDimension = 1024;

  // Alpha at or above this value packs as an opaque RGB5A3 word
  localparam logic [7:0] OpaqueAlpha = 8'd237;

  // Byte distance from the alpha/red half to the green/blue half of a tile
  localparam logic [AddrW-1:0] HalfTileBytes = AddrW'(32);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEST_WIDTH   = 3'd0,
    CFG_DEST_HEIGHT  = 3'd1,
    CFG_HIGH_PREC    = 3'd2,
    CFG_OFFSET_X     = 3'd3,
    CFG_OFFSET_Y     = 3'd4,
    CFG_BASE_ADDRESS = 3'd5
  } ttpw_cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0]  dest_width;
    logic [DimW-1:0]  dest_height;
    logic             high_precision;
    logic [OffsW-1:0] offset_x;
    logic [OffsW-1:0] offset_y;
    logic [BaseW-1:0] base_address;
  } ttpw_cfg_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_rgba;
    logic [CoordW-1:0] src_y;
    logic [CoordW-1:0] src_x;
  } ttpw_req_t;

  typedef struct packed {
    logic             second_valid;
    logic [WordW-1:0] second_data;
    logic [AddrW-1:0] second_address;
    logic [WordW-1:0] first_data;
    logic [AddrW-1:0] first_address;
  } ttpw_res_t;

  // Pack 8-bit channels into one RGB5A3 word
  function automatic logic [WordW-1:0] ttpw_pack_rgb5a3(
    input logic [7:0] r,
    input logic [7:0] g,
    input logic [7:0] b,
    input logic [7:0] a
  );
    logic [WordW-1:0] word;
    if (a >= OpaqueAlpha) begin
      word = {1'b1, r[7:3], g[7:3], b[7:3]};
    end else begin
      word = {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
    end
    return word;
  endfunction

endpackage

// ===== rtl/ttpw_core.sv =====
// Address and data path of the tiled texture pixel writer: offset, bounds
// check, 4x4 tile addressing and texel format packing. Depends on ttpw_pkg.

module ttpw_core (
  input  ttpw_pkg::ttpw_cfg_t cfg_i,
  input  ttpw_pkg::ttpw_req_t req_i,
  output logic                keep_o,
  output ttpw_pkg::ttpw_res_t res_o
);
  import ttpw_pkg::*;

  logic [DimW-1:0]    width_c;
  logic [DimW-1:0]    height_c;
  logic [DimW:0]      px;
  logic [DimW:0]      py;
  logic [CoordW-1:0]  ux;
  logic [CoordW-1:0]  uy;
  logic [DimW:0]      tw_sum;
  logic [8:0]         tiles_wide;
  logic [16:0]        row_prod;
  logic [TileW-1:0]   tile;
  logic [3:0]         slot;
  logic [AddrW-1:0]   offs_lp;
  logic [AddrW-1:0]   offs_hp;
  logic [AddrW-1:0]   addr;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;

  // Clamp level size to the largest supported edge
  assign width_c  = (cfg_i.dest_width > DimW'(MaxDimension)) ?
                    DimW'(MaxDimension) : cfg_i.dest_width;
  assign height_c = (cfg_i.dest_height > DimW'(MaxDimension)) ?
                    DimW'(MaxDimension) : cfg_i.dest_height;

  // Destination texel, signed 12 bits
  assign px = {cfg_i.offset_x[OffsW-1], cfg_i.offset_x} + {2'b00, req_i.src_x};
  assign py = {cfg_i.offset_y[OffsW-1], cfg_i.offset_y} + {2'b00, req_i.src_y};

  // Drop texels outside the level
  assign keep_o = !px[DimW] && !py[DimW] &&
                  (px[DimW-1:0] < width_c) && (py[DimW-1:0] < height_c);

  assign ux = px[CoordW-1:0];
  assign uy = py[CoordW-1:0];

  // Tile row stride is ceil(width / 4)
  assign tw_sum     = {1'b0, width_c} + (DimW+1)'(3);
  assign tiles_wide = tw_sum[DimW-1:2];
  assign row_prod   = uy[CoordW-1:2] * tiles_wide;
  assign tile       = row_prod[TileW-1:0] + TileW'(ux[CoordW-1:2]);
  assign slot       = {uy[1:0], ux[1:0]};

  // Byte offset inside the level: 32-byte or 64-byte tiles, 2 bytes a texel
  assign offs_lp = AddrW'({tile, slot, 1'b0});
  assign offs_hp = AddrW'({tile, 1'b0, slot, 1'b0});
  assign addr    = AddrW'(cfg_i.base_address) +
                   (cfg_i.high_precision ? offs_hp : offs_lp);

  assign red   = req_i.pixel_rgba[31:24];
  assign green = req_i.pixel_rgba[23:16];
  assign blue  = req_i.pixel_rgba[15:8];
  assign alpha = req_i.pixel_rgba[7:0];

  // Build the result words for the selected format
  always_comb begin
    res_o.first_address = addr;
    if (cfg_i.high_precision) begin
      res_o.first_data     = {alpha, red};
      res_o.second_address = addr + HalfTileBytes;
      res_o.second_data    = {green, blue};
      res_o.second_valid   = 1'b1;
    end else begin
      res_o.first_data     = ttpw_pack_rgb5a3(red, green, blue, alpha);
      res_o.second_address = '0;
      res_o.second_data    = '0;
      res_o.second_valid   = 1'b0;
    end
  end

endmodule

// ===== rtl/tiled_texture_pixel_writer_top.sv =====
// Tiled texture pixel writer: configuration registers, input request
// register, result register and handshake. Depends on ttpw_pkg, ttpw_core.

// Takes RGBA8 pixel requests, one per clock while the output does not stall,
// and, unless the pixel lands outside the destination level, returns the
// byte address and 16-bit word (RGB5A3) or the two words (RGBA8, second
// word 32 bytes on) to write into a 4x4-tiled texture. The request sits in
// the input register, then offset, bounds check, tile multiply and packing
// run in one combinational pass into the result register. Throughput is one
// request per clock with no bubbles while the output is not stalled. Dropped
// pixels give no result and never stall the input. Write configuration only
// while no request is in flight.

module tiled_texture_pixel_writer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [ttpw_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ttpw_pkg::CfgDataW-1:0]   cfg_data_i,
  // Pixel requests
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // fields from bit 0: src_x[9:0], src_y[19:10], pixel_rgba[51:20], zero pad
  input  logic [ttpw_pkg::SInW-1:0]       s_axis_tdata,
  // Write results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fields from bit 0: first_address[24:0], first_data[40:25],
  // second_address[65:41], second_data[81:66], zero pad
  output logic [ttpw_pkg::MOutW-1:0]      m_axis_tdata,
  // fields from bit 0: second_valid
  output logic                            m_axis_tuser
);
  import ttpw_pkg::*;

  ttpw_cfg_t cfg_q;
  logic      in_vld_q;
  ttpw_req_t in_req_q;
  logic      out_vld_q;
  ttpw_res_t out_res_q;
  logic      keep;
  ttpw_res_t res;
  logic      out_free;
  logic      in_adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_width     <= DimW'(1);
      cfg_q.dest_height    <= DimW'(1);
      cfg_q.high_precision <= 1'b0;
      cfg_q.offset_x       <= '0;
      cfg_q.offset_y       <= '0;
      cfg_q.base_address   <= '0;
    end else if (cfg_we_i) begin
      unique case (ttpw_cfg_idx_e'(cfg_index_i))
        CFG_DEST_WIDTH:   cfg_q.dest_width     <= cfg_data_i[DimW-1:0];
        CFG_DEST_HEIGHT:  cfg_q.dest_height    <= cfg_data_i[DimW-1:0];
        CFG_HIGH_PREC:    cfg_q.high_precision <= cfg_data_i[0];
        CFG_OFFSET_X:     cfg_q.offset_x       <= cfg_data_i[OffsW-1:0];
        CFG_OFFSET_Y:     cfg_q.offset_y       <= cfg_data_i[OffsW-1:0];
        CFG_BASE_ADDRESS: cfg_q.base_address   <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  ttpw_core u_core (
    .cfg_i  (cfg_q),
    .req_i  (in_req_q),
    .keep_o (keep),
    .res_o  (res)
  );

  // Advance the held request when it is dropped or the result slot frees up
  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_adv        = in_vld_q && (!keep || out_free);
  assign s_axis_tready = !in_vld_q || in_adv;

  // Input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q <= ttpw_req_t'(s_axis_tdata[51:0]);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && keep && out_free) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.second_valid;
  assign m_axis_tdata  = {6'b0, out_res_q.second_data, out_res_q.second_address,
                          out_res_q.first_data, out_res_q.first_address};

`ifndef SYNTH
  // A kept request waiting on a stalled output stays held
  a_hold_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && keep && !out_free |=> in_vld_q && $stable(in_req_q))
    else $error("kept request lost while output stalled");

  // Input stalls only with a request held
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q)
    else $error("input stalled with empty request register");

  // Green/blue word sits half a tile after the alpha/red word
  a_second_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      out_res_q.second_address == out_res_q.first_address + HalfTileBytes)
    else $error("second word address is not first plus half tile");

  // RGB5A3 results carry zeroed second word fields
  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      out_res_q.second_address == '0 && out_res_q.second_data == '0)
    else $error("second word fields not zero in RGB5A3 mode");
`endif

endmodule

// ===== bench/tiled_texture_pixel_writer_top_tb.sv =====
// Self-checking bench for tiled_texture_pixel_writer_top: streams pixel requests,
// predicts each tiled texture write in a local model and checks every result.
// Depends on ttpw_pkg and the RTL top level only.

module tiled_texture_pixel_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttpw_pkg::*;

  localparam int HoldOffCycles = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // fields from bit 0: src_x[9:0], src_y[19:10], pixel_rgba[51:20], zero pad
  logic [SInW-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // fields from bit 0: first_address[24:0], first_data[40:25],
  // second_address[65:41], second_data[81:66], zero pad
  logic [MOutW-1:0]    m_axis_tdata;
  // fields from bit 0: second_valid
  logic                m_axis_tuser;

  // Local copy of the level registers and the writes still owed by the block
  ttpw_cfg_t level_cfg;
  ttpw_res_t pending_writes[$];
  int        error_count;
  bit        tx_idle_en;
  bit        rx_idle_en;
  bit        hold_off_req;

  tiled_texture_pixel_writer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock: 8 ns period
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp a level edge to the largest supported size
  function automatic int effective_dim(input logic [DimW-1:0] dim);
    return (dim > DimW'(MaxDimension)) ? int'(MaxDimension) : int'(dim);
  endfunction

  // Pack 8-bit channels into a 16-bit RGB5A3 texel
  function automatic logic [WordW-1:0] rgb5a3_word(input logic [7:0] r, g, b, a);
    logic [WordW-1:0] word;
    if (a >= 8'd237) begin
      word = 16'h8000 | (16'(r & 8'hf8) << 7) | (16'(g & 8'hf8) << 2)
           | (16'(b & 8'hf8) >> 3);
    end else begin
      word = (16'(a & 8'he0) << 7) | (16'(r & 8'hf0) << 4) | 16'(g & 8'hf0)
           | (16'(b & 8'hf0) >> 4);
    end
    return word;
  endfunction

  // Work out the texture write for one pixel; return 0 when it is dropped
  function automatic bit predict_texel_write(input ttpw_req_t req, output ttpw_res_t res);
    int               w, h, px, py, tiles_wide, tile, slot;
    logic [7:0]       r, g, b, a;
    logic [AddrW-1:0] addr;
    res = '0;
    w  = effective_dim(level_cfg.dest_width);
    h  = effective_dim(level_cfg.dest_height);
    px = int'($signed(level_cfg.offset_x)) + int'(req.src_x);
    py = int'($signed(level_cfg.offset_y)) + int'(req.src_y);
    if (px < 0 || py < 0 || px >= w || py >= h) return 1'b0;
    tiles_wide = (w + 3) / 4;
    tile = (py / 4) * tiles_wide + px / 4;
    slot = (py % 4) * 4 + px % 4;
    {r, g, b, a} = req.pixel_rgba;
    if (level_cfg.high_precision) begin
      addr = AddrW'(level_cfg.base_address) + AddrW'(tile * 64 + slot * 2);
      res.first_address  = addr;
      res.first_data     = {a, r};
      res.second_address = addr + AddrW'(32);
      res.second_data    = {g, b};
      res.second_valid   = 1'b1;
    end else begin
      addr = AddrW'(level_cfg.base_address) + AddrW'(tile * 32 + slot * 2);
      res.first_address = addr;
      res.first_data    = rgb5a3_word(r, g, b, a);
    end
    return 1'b1;
  endfunction

  // Write one level register and mirror it locally
  task automatic write_level_reg(input ttpw_cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    case (idx)
      CFG_DEST_WIDTH:   level_cfg.dest_width     = val[DimW-1:0];
      CFG_DEST_HEIGHT:  level_cfg.dest_height    = val[DimW-1:0];
      CFG_HIGH_PREC:    level_cfg.high_precision = val[0];
      CFG_OFFSET_X:     level_cfg.offset_x       = val[OffsW-1:0];
      CFG_OFFSET_Y:     level_cfg.offset_y       = val[OffsW-1:0];
      CFG_BASE_ADDRESS: level_cfg.base_address   = val[BaseW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_level(input int w, h, input bit hp, input int ox, oy,
                           input logic [BaseW-1:0] base);
    write_level_reg(CFG_DEST_WIDTH, CfgDataW'(DimW'(w)));
    write_level_reg(CFG_DEST_HEIGHT, CfgDataW'(DimW'(h)));
    write_level_reg(CFG_HIGH_PREC, CfgDataW'(hp));
    write_level_reg(CFG_OFFSET_X, CfgDataW'(OffsW'(ox)));
    write_level_reg(CFG_OFFSET_Y, CfgDataW'(OffsW'(oy)));
    write_level_reg(CFG_BASE_ADDRESS, CfgDataW'(base));
  endtask

  // Offer one pixel request, hold it until accepted, log the expected write
  task automatic push_pixel(input logic [CoordW-1:0] sx, sy, input logic [PixelW-1:0] rgba);
    ttpw_req_t req;
    ttpw_res_t res;
    int        gap;
    @(negedge clk_i);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk_i);
    end
    req.src_x      = sx;
    req.src_y      = sy;
    req.pixel_rgba = rgba;
    s_axis_tdata   = SInW'(req);
    s_axis_tvalid  = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_texel_write(req, res)) pending_writes.push_back(res);
  endtask

  // Stop offering, wait for every owed write, then let dropped requests clear
  task automatic drain_writes();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Pick a source coordinate that mostly lands in or just around the level
  function automatic logic [CoordW-1:0] aim_coord(input int dim, input logic [OffsW-1:0] off);
    int t;
    t = int'($urandom_range(0, dim + 3)) - 2 - int'($signed(off));
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return CoordW'(t);
  endfunction

  function automatic logic [PixelW-1:0] random_pixel();
    logic [PixelW-1:0] pix;
    pix = $urandom;
    case ($urandom_range(0, 3))
      0: pix[7:0] = 8'd236;
      1: pix[7:0] = 8'd237;
      default: ;
    endcase
    return pix;
  endfunction

  // Register defaults after reset: a 1x1 RGB5A3 level at address zero
  task automatic test_reset_defaults();
    push_pixel(10'd0, 10'd0, 32'hFFFF_FFFF);
    push_pixel(10'd0, 10'd0, 32'h0000_0000);
    push_pixel(10'd1, 10'd0, 32'h1234_5678);
    push_pixel(10'd0, 10'd1, 32'h1234_5678);
    push_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
    drain_writes();
  endtask

  // Field extremes, both formats, alpha threshold, offsets, odd and bad sizes
  task automatic test_directed_edges();
    set_level(1024, 1024, 1'b1, 0, 0, 24'hFF_FFFF);
    push_pixel(10'd0, 10'd0, 32'h1234_5678);
    push_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
    push_pixel(10'd3, 10'd5, 32'h0000_0000);
    drain_writes();

    // width 5 needs a tile stride of two
    set_level(5, 7, 1'b0, 0, 0, 24'h00_0000);
    push_pixel(10'd4, 10'd6, 32'hA5C3_3CED);
    push_pixel(10'd4, 10'd6, 32'hA5C3_3CEC);
    push_pixel(10'd3, 10'd2, 32'hFFFF_FF00);
    push_pixel(10'd2, 10'd1, 32'h8877_66E0);
    push_pixel(10'd5, 10'd0, 32'h1111_1111);
    push_pixel(10'd0, 10'd7, 32'h1111_1111);
    drain_writes();

    // oversized edges clamp to the largest level, offsets at both extremes
    set_level(2047, 2047, 1'b1, 1023, -4, 24'h80_0000);
    push_pixel(10'd0, 10'd4, 32'hDEAD_BEEF);
    push_pixel(10'd1, 10'd4, 32'hDEAD_BEEF);
    push_pixel(10'd0, 10'd3, 32'hDEAD_BEEF);
    drain_writes();
    set_level(2047, 2047, 1'b0, -1024, 1023, 24'h00_1000);
    push_pixel(10'd1023, 10'd0, 32'hCAFE_F00D);
    push_pixel(10'd1023, 10'd1, 32'hCAFE_F00D);
    drain_writes();
    write_level_reg(CFG_OFFSET_X, CfgDataW'(OffsW'(-3)));
    push_pixel(10'd3, 10'd0, 32'hCAFE_F00D);
    drain_writes();

    // zero edges drop everything
    set_level(0, 8, 1'b0, 0, 0, 24'h00_0000);
    push_pixel(10'd0, 10'd0, 32'hFFFF_FFFF);
    drain_writes();
    write_level_reg(CFG_DEST_WIDTH, CfgDataW'(DimW'(8)));
    write_level_reg(CFG_DEST_HEIGHT, CfgDataW'(DimW'(0)));
    push_pixel(10'd0, 10'd0, 32'hFFFF_FFFF);
    drain_writes();
  endtask

  // Random levels with mostly in-range coordinates and some stray ones
  task automatic test_random_traffic(input int phases, input int per_phase);
    int w, h, ox, oy, sel;
    logic [CoordW-1:0] sx, sy;
    for (int p = 0; p < phases; p++) begin
      sel = $urandom_range(0, 9);
      w = (sel < 6) ? $urandom_range(1, 40) : (sel < 8) ? $urandom_range(41, 1024)
        : (sel == 8) ? $urandom_range(1025, 2047) : 1024;
      sel = $urandom_range(0, 9);
      h = (sel < 6) ? $urandom_range(1, 40) : (sel < 8) ? $urandom_range(41, 1024)
        : (sel == 8) ? $urandom_range(1025, 2047) : 1024;
      ox = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 32)) - 16
         : int'($urandom_range(0, 2047)) - 1024;
      oy = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 32)) - 16
         : int'($urandom_range(0, 2047)) - 1024;
      set_level(w, h, 1'($urandom_range(0, 1)), ox, oy, BaseW'($urandom));
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(0, 19);
        if (sel < 17) begin
          sx = aim_coord(effective_dim(level_cfg.dest_width), level_cfg.offset_x);
          sy = aim_coord(effective_dim(level_cfg.dest_height), level_cfg.offset_y);
        end else begin
          sx = CoordW'($urandom);
          sy = CoordW'($urandom);
          if (sel == 19) sx = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
        end
        push_pixel(sx, sy, random_pixel());
      end
      drain_writes();
    end
  endtask

  // Stall the output long enough to back up the input, then pause mid-stream
  task automatic test_backpressure();
    set_level(64, 64, 1'b1, 0, 0, 24'h12_3456);
    @(posedge clk_i);
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      push_pixel(CoordW'($urandom_range(0, 63)), CoordW'($urandom_range(0, 63)),
                 random_pixel());
    end
    drain_writes();
    for (int i = 0; i < 40; i++) begin
      push_pixel(CoordW'($urandom_range(0, 63)), CoordW'($urandom_range(0, 63)),
                 random_pixel());
    end
    drain_writes();
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_off_req  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready = 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Compare each accepted write with the oldest expected one
  always @(posedge clk_i) begin : check_writes
    ttpw_res_t got;
    ttpw_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = ttpw_res_t'({m_axis_tuser, m_axis_tdata[81:0]});
      if (pending_writes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected write addr %h data %h addr2 %h data2 %h v %b", $realtime,
                   got.first_address, got.first_data, got.second_address,
                   got.second_data, got.second_valid);
      end else begin
        want = pending_writes.pop_front();
        if (got.first_address !== want.first_address || got.first_data !== want.first_data ||
            got.second_address !== want.second_address ||
            got.second_data !== want.second_data || got.second_valid !== want.second_valid)
        begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: write mismatch", $realtime);
            $display("  expected addr %h data %h addr2 %h data2 %h v %b",
                     want.first_address, want.first_data, want.second_address,
                     want.second_data, want.second_valid);
            $display("  actual   addr %h data %h addr2 %h data2 %h v %b",
                     got.first_address, got.first_data, got.second_address,
                     got.second_data, got.second_valid);
          end
        end
      end
    end
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_DEST_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    error_count   = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    level_cfg     = '0;
    level_cfg.dest_width  = DimW'(1);
    level_cfg.dest_height = DimW'(1);
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_directed_edges();
    test_random_traffic(8, 150);
    test_backpressure();
    // final stretch at full rate on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(1, 150);

    drain_writes();
    repeat (8) @(posedge clk_i);
    error_count += pending_writes.size();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
